@@ hw/rtl/dtee_pkg.sv @@
// ============================================================================
// dtee_pkg: shared constants and ROM functions
// Digit codes, effect codes, command codes and segment stage tables.
// ============================================================================
package dtee_pkg;

   localparam int DIGITS_DEF = 6;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_PAT   = 2'd1;
   localparam logic [1:0] CMD_DUTY  = 2'd2;
   localparam logic [1:0] CMD_START = 2'd3;

   localparam logic [2:0] EFF_NONE  = 3'd0;
   localparam logic [2:0] EFF_FADE  = 3'd1;
   localparam logic [2:0] EFF_XFADE = 3'd2;
   localparam logic [2:0] EFF_DRAW  = 3'd3;
   localparam logic [2:0] EFF_HROLL = 3'd4;
   localparam logic [2:0] EFF_VROLL = 3'd5;

   localparam logic [15:0] HIGH_KEEP = 16'hFF80;

   localparam logic [6:0] SA = 7'h01;
   localparam logic [6:0] SB = 7'h02;
   localparam logic [6:0] SC = 7'h04;
   localparam logic [6:0] SD = 7'h08;
   localparam logic [6:0] SE = 7'h10;
   localparam logic [6:0] SF = 7'h20;
   localparam logic [6:0] SG = 7'h40;

   // Numeral shown by segments a-g, or 10 when no numeral matches.
   function automatic logic [3:0] decode_digit(input logic [6:0] p);
      unique case (p)
         7'h3F: decode_digit = 4'd0;
         7'h06: decode_digit = 4'd1;
         7'h5B: decode_digit = 4'd2;
         7'h4F: decode_digit = 4'd3;
         7'h66: decode_digit = 4'd4;
         7'h6D: decode_digit = 4'd5;
         7'h7D: decode_digit = 4'd6;
         7'h07: decode_digit = 4'd7;
         7'h7F: decode_digit = 4'd8;
         7'h6F: decode_digit = 4'd9;
         default: decode_digit = 4'd10;
      endcase
   endfunction

   function automatic logic [6:0] draw_rom(input logic [3:0] n, input logic [2:0] s);
      logic [6:0] r [7];
      r = '{default: 7'd0};
      unique case (n)
         4'd0: r = '{SA, SA|SF, SA|SF|SE, SA|SF|SE|SD, SA|SF|SE|SD, SA|SF|SE|SD|SC,
                     SA|SF|SE|SD|SC|SB};
         4'd1: r = '{SB, SB|SC, SB|SC, SB|SC, SB|SC, SB|SC, SB|SC};
         4'd2: r = '{SA, SA|SB, SA|SB|SG, SA|SB|SG|SE, SA|SB|SG|SE|SD, SA|SB|SG|SE|SD,
                     SA|SB|SG|SE|SD};
         4'd3: r = '{SA, SA|SB, SA|SB|SG, SA|SB|SG|SC, SA|SB|SG|SC|SD, SA|SB|SG|SC|SD,
                     SA|SB|SG|SC|SD};
         4'd4: r = '{SF, SF|SG, SF|SG|SB, SF|SG|SB|SC, SF|SG|SB|SC, SF|SG|SB|SC,
                     SF|SG|SB|SC};
         4'd5: r = '{SA, SA|SF, SA|SF|SG, SA|SF|SG|SC, SA|SF|SG|SC|SD, SA|SF|SG|SC|SD,
                     SA|SF|SG|SC|SD};
         4'd6: r = '{SA, SA|SF, SA|SF|SE, SA|SF|SE|SD, SA|SF|SE|SD|SC,
                     SA|SF|SE|SD|SC|SG, SA|SF|SE|SD|SC|SG};
         4'd7: r = '{SA, SA|SB, SA|SB|SC, SA|SB|SC, SA|SB|SC, SA|SB|SC, SA|SB|SC};
         4'd8: r = '{SA, SA|SF, SA|SF|SG, SA|SF|SG|SC, SA|SF|SG|SC|SD,
                     SA|SF|SG|SC|SD|SE, SA|SF|SG|SC|SD|SE|SB};
         4'd9: r = '{SB, SB|SA, SB|SA|SF, SB|SA|SF|SG, SB|SA|SF|SG|SC,
                     SB|SA|SF|SG|SC|SD, SB|SA|SF|SG|SC|SD};
         default: r = '{default: 7'd0};
      endcase
      draw_rom = (s < 3'd7) ? r[s] : 7'd0;
   endfunction

   function automatic logic [6:0] hroll_rom(input logic [3:0] n, input logic [2:0] s,
                                            input logic in);
      logic [6:0] o [3];
      logic [6:0] i [3];
      o = '{default: 7'd0};
      i = '{default: 7'd0};
      unique case (n)
         4'd0: begin
            o = '{SA|SB|SC|SD|SE|SF, SA|SB|SC|SD, SB|SC};
            i = '{SE|SF, SA|SD|SE|SF, SA|SB|SC|SD|SE|SF};
         end
         4'd1: begin
            o = '{SB|SC, SB|SC, SB|SC};
            i = '{7'd0, 7'd0, SB|SC};
         end
         4'd2: begin
            o = '{SA|SB|SD|SE|SG, SA|SB|SD|SG, SB};
            i = '{SE, SA|SD|SE|SG, SA|SB|SD|SE|SG};
         end
         4'd3: begin
            o = '{SA|SB|SC|SD|SG, SA|SB|SC|SD|SG, SB|SC};
            i = '{7'd0, SA|SD|SG, SA|SB|SC|SD|SG};
         end
         4'd4: begin
            o = '{SB|SC|SF|SG, SB|SC|SG, SB|SC};
            i = '{SF, SF|SG, SB|SC|SF|SG};
         end
         4'd5: begin
            o = '{SA|SC|SD|SF|SG, SA|SC|SD|SG, SC};
            i = '{SF, SA|SD|SF|SG, SA|SC|SD|SF|SG};
         end
         4'd6: begin
            o = '{SA|SC|SD|SE|SF|SG, SA|SC|SD|SG, SC};
            i = '{SE|SF, SA|SD|SE|SF|SG, SA|SC|SD|SE|SF|SG};
         end
         4'd7: begin
            o = '{SA|SB|SC, SA|SB|SC, SB|SC};
            i = '{7'd0, SA, SA|SB|SC};
         end
         4'd8: begin
            o = '{SA|SB|SC|SD|SE|SF|SG, SA|SB|SC|SD|SG, SB|SC};
            i = '{SE|SF, SA|SD|SE|SF|SG, SA|SB|SC|SD|SE|SF|SG};
         end
         4'd9: begin
            o = '{SA|SB|SC|SD|SF|SG, SA|SB|SC|SD|SG, SB|SC};
            i = '{SF, SA|SD|SF|SG, SA|SB|SC|SD|SF|SG};
         end
         default: begin
            o = '{default: 7'd0};
            i = '{default: 7'd0};
         end
      endcase
      if (s < 3'd3) hroll_rom = in ? i[s[1:0]] : o[s[1:0]];
      else hroll_rom = 7'd0;
   endfunction

   function automatic logic [6:0] vroll_rom(input logic [3:0] n, input logic [2:0] s,
                                            input logic in);
      logic [6:0] o [5];
      logic [6:0] i [5];
      o = '{default: 7'd0};
      i = '{default: 7'd0};
      unique case (n)
         4'd0: begin
            o = '{SA|SB|SC|SD|SE|SF, SB|SC|SD|SE|SF, SC|SD|SE, SC|SD|SE, SD};
            i = '{SA, SA|SB|SF, SA|SB|SF, SA|SB|SC|SE|SF, SA|SB|SC|SD|SE|SF};
         end
         4'd1: begin
            o = '{SB|SC, SB|SC, SC, SC, 7'd0};
            i = '{7'd0, SB, SB, SB|SC, SB|SC};
         end
         4'd2: begin
            o = '{SA|SB|SD|SE|SG, SB|SD|SE|SG, SD|SE|SG, SD|SE, SD};
            i = '{SA, SA|SB, SA|SB|SG, SA|SB|SE|SG, SA|SB|SD|SE|SG};
         end
         4'd3: begin
            o = '{SA|SB|SC|SD|SG, SB|SC|SD|SG, SC|SD|SG, SC|SD, SD};
            i = '{SA, SA|SB, SA|SB|SG, SA|SB|SC|SG, SA|SB|SC|SD|SG};
         end
         4'd4: begin
            o = '{SB|SC|SF|SG, SB|SC|SF|SG, SC|SG, SC, 7'd0};
            i = '{7'd0, SB|SF, SB|SF|SG, SB|SC|SF|SG, SB|SC|SF|SG};
         end
         4'd5: begin
            o = '{SA|SC|SD|SF|SG, SC|SD|SF|SG, SC|SD|SG, SC|SD, SD};
            i = '{SA, SA|SF, SA|SF|SG, SA|SC|SF|SG, SA|SC|SD|SF|SG};
         end
         4'd6: begin
            o = '{SA|SC|SD|SE|SF|SG, SC|SD|SE|SF|SG, SC|SD|SE|SG, SC|SD|SE, SD};
            i = '{SA, SA|SF, SA|SF|SG, SA|SC|SE|SF|SG, SA|SC|SD|SE|SF|SG};
         end
         4'd7: begin
            o = '{SA|SB|SC, SB|SC, SC, SC, 7'd0};
            i = '{SA, SA|SB, SA|SB, SA|SB|SC, SA|SB|SC};
         end
         4'd8: begin
            o = '{SA|SB|SC|SD|SE|SF|SG, SB|SC|SD|SE|SF|SG, SC|SD|SE|SG, SC|SD|SE, SD};
            i = '{SA, SA|SB|SF, SA|SB|SF|SG, SA|SB|SC|SE|SF|SG, SA|SB|SC|SD|SE|SF|SG};
         end
         4'd9: begin
            o = '{SA|SB|SC|SD|SF|SG, SB|SC|SD|SF|SG, SC|SD|SG, SC|SD, SD};
            i = '{SA, SA|SB|SF, SA|SB|SF|SG, SA|SB|SC|SF|SG, SA|SB|SC|SD|SF|SG};
         end
         default: begin
            o = '{default: 7'd0};
            i = '{default: 7'd0};
         end
      endcase
      if (s < 3'd5) vroll_rom = in ? i[s] : o[s];
      else vroll_rom = 7'd0;
   endfunction

endpackage

@@ hw/rtl/digit_transition_effect_engine.sv @@
// ============================================================================
// digit_transition_effect_engine
// Seven-segment transition animator: per-digit state in one memory, a tick
// reads, updates and writes back every digit in turn.
// ============================================================================
// Sequence: a tick is taken in IDLE; each digit then passes READ (read),
// CALC (update and write back) and OUT (output register) in turn.
// Flow: a tick holds off the input until every digit is done, longer while
// the response side stalls; store and start requests are taken every cycle
// while idle. Reset: synchronous; a clearing pass zeroes the state memory
// after reset, during which no request is taken.
module digit_transition_effect_engine
   import dtee_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] cmd, [4:2] digit, [20:5] value, [23:21] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] digit_index, [18:3] seg_primary, [34:19] duty_out,
   // [50:35] seg_secondary, [57:51] blend_ratio, [63:58] zero
   output logic [63:0] rsp_tdata,
   // [0] seg_valid, [1] duty_valid, [2] blend_valid
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);

   localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   typedef struct packed {
      logic [15:0] nx;
      logic [15:0] prev;
      logic [15:0] duty;
      logic        chg;
      logic [8:0]  cnt;
   } entry_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CALC  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [2:0]  idx;
      logic        sv;
      logic [15:0] sp;
      logic        dv;
      logic [15:0] du;
      logic        bv;
      logic [15:0] ss;
      logic [6:0]  br;
      logic        last;
   } rsp_type;

   entry_type mem [DIGITS];
   entry_type rd_ff;

   state_type   state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [2:0]  mode_ff;
   logic        mul_ff, mul_in;
   logic [15:0] mdu_ff;
   logic [7:0]  mfac_ff;
   logic [24:0] prod;
   rsp_type     pend_ff, pend_in;
   rsp_type     out_ff;
   rsp_type     out_in;
   logic        ovalid_ff;

   logic        we;
   logic [AW-1:0] waddr;
   entry_type   wdata;
   entry_type   upd;
   logic [15:0] mdu_in;
   logic [7:0]  mfac_in;

   logic [1:0]  cmd;
   logic [2:0]  dig;
   logic [15:0] val;
   assign cmd = req_tdata[1:0];
   assign dig = req_tdata[4:2];
   assign val = req_tdata[20:5];

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);

   logic out_free;
   assign out_free = !ovalid_ff || rsp_tready;

   // Per-digit update and response.
   logic [8:0]  c1;
   logic [6:0]  lowst;
   logic [15:0] src;
   logic [2:0]  stg;
   logic        inc;
   logic [3:0]  sn;
   logic [3:0]  q70;
   logic [4:0]  q30;
   logic [8:0]  dsub;
   always_comb begin
      upd = rd_ff;
      pend_in = '0;
      pend_in.idx = 3'(ptr_ff);
      pend_in.last = (ptr_ff == AW'(DIGITS - 1));
      mul_in = 1'b0;
      mdu_in = rd_ff.duty;
      mfac_in = 8'd0;
      c1 = rd_ff.cnt + 9'd1;
      lowst = 7'd0;
      src = rd_ff.nx;
      stg = 3'd0;
      inc = 1'b0;
      sn = 4'd10;
      q70 = 4'd0;
      q30 = 5'd0;
      dsub = c1 - 9'd100;
      unique case (mode_ff)
         EFF_NONE: begin
            pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx;
            pend_in.dv = 1'b1; pend_in.du = rd_ff.duty;
         end
         EFF_FADE: begin
            if (rd_ff.chg) begin
               upd.cnt = c1;
               if (c1 < 9'd129) begin
                  mul_in = 1'b1; pend_in.dv = 1'b1;
                  mfac_in = 8'(9'd128 - c1);
               end else if (c1 < 9'd257) begin
                  mul_in = 1'b1; pend_in.dv = 1'b1;
                  mfac_in = 8'(c1 - 9'd128);
                  pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx;
               end else begin
                  upd.cnt = 9'd0; upd.chg = 1'b0;
               end
            end else begin
               pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx;
               pend_in.dv = 1'b1; pend_in.du = rd_ff.duty;
            end
         end
         EFF_XFADE: begin
            pend_in.dv = 1'b1; pend_in.du = rd_ff.duty;
            pend_in.bv = 1'b1;
            if (rd_ff.chg) begin
               pend_in.br = (rd_ff.cnt > 9'd127) ? 7'd127 : rd_ff.cnt[6:0];
               pend_in.ss = rd_ff.nx;
               if (rd_ff.cnt >= 9'd127) begin
                  upd.cnt = 9'd0; upd.chg = 1'b0;
               end else begin
                  upd.cnt = c1;
               end
            end else begin
               upd.prev = rd_ff.nx;
               pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx;
            end
         end
         EFF_DRAW: begin
            pend_in.dv = 1'b1; pend_in.du = rd_ff.duty;
            if (rd_ff.chg) begin
               upd.cnt = c1;
               if (c1 < 9'd100) begin
                  pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx & HIGH_KEEP;
               end else if (c1 < 9'd380) begin
                  // Stage index (c-100)/40, at most 6.
                  priority if (dsub >= 9'd240) stg = 3'd6;
                  else if (dsub >= 9'd200) stg = 3'd5;
                  else if (dsub >= 9'd160) stg = 3'd4;
                  else if (dsub >= 9'd120) stg = 3'd3;
                  else if (dsub >= 9'd80) stg = 3'd2;
                  else if (dsub >= 9'd40) stg = 3'd1;
                  else stg = 3'd0;
                  sn = decode_digit(rd_ff.nx[6:0]);
                  lowst = draw_rom(sn, stg);
                  pend_in.sv = 1'b1;
                  pend_in.sp = {rd_ff.nx[15:7], lowst};
               end else begin
                  upd.cnt = 9'd0; upd.chg = 1'b0;
               end
            end else begin
               pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx;
            end
         end
         EFF_HROLL, EFF_VROLL: begin
            pend_in.dv = 1'b1; pend_in.du = rd_ff.duty;
            if (rd_ff.chg) begin
               upd.cnt = c1;
               priority if (c1 >= 9'd420) q70 = 4'd6;
               else if (c1 >= 9'd350) q70 = 4'd5;
               else if (c1 >= 9'd280) q70 = 4'd4;
               else if (c1 >= 9'd210) q70 = 4'd3;
               else if (c1 >= 9'd140) q70 = 4'd2;
               else if (c1 >= 9'd70) q70 = 4'd1;
               else q70 = 4'd0;
               q30 = 5'((19'(c1) * 19'd547) >> 14);
               if (mode_ff == EFF_HROLL) begin
                  if (q70 < 4'd6) begin
                     inc = (q70 >= 4'd3);
                     stg = inc ? 3'(q70 - 4'd3) : q70[2:0];
                     src = inc ? rd_ff.nx : rd_ff.prev;
                     sn = decode_digit(src[6:0]);
                     lowst = hroll_rom(sn, stg, inc);
                     pend_in.sv = 1'b1; pend_in.sp = {src[15:7], lowst};
                  end else begin
                     upd.cnt = 9'd0; upd.chg = 1'b0;
                  end
               end else begin
                  if (q30 < 5'd10) begin
                     inc = (q30 >= 5'd5);
                     stg = inc ? 3'(q30 - 5'd5) : q30[2:0];
                     src = inc ? rd_ff.nx : rd_ff.prev;
                     sn = decode_digit(src[6:0]);
                     lowst = vroll_rom(sn, stg, inc);
                     pend_in.sv = 1'b1; pend_in.sp = {src[15:7], lowst};
                  end else begin
                     upd.cnt = 9'd0; upd.chg = 1'b0;
                  end
               end
            end else begin
               pend_in.sv = 1'b1; pend_in.sp = rd_ff.nx;
               upd.prev = rd_ff.nx;
            end
         end
         default: begin
            pend_in = '0;
            pend_in.idx = 3'(ptr_ff);
            pend_in.last = (ptr_ff == AW'(DIGITS - 1));
         end
      endcase
   end

   // State machine: READ issues the memory read, CALC updates and writes
   // back, OUT applies the fade multiply and hands over to the output register.
   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      we = 1'b0;
      waddr = ptr_ff;
      wdata = upd;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; wdata = '0;
            if (ptr_ff == AW'(DIGITS - 1)) begin
               ptr_in = '0; state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid && cmd == CMD_TICK) begin
               ptr_in = '0; state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_CALC;
         ST_CALC: begin
            we = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               if (pend_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Store and start requests modify one entry: read now, write next cycle.
   // A second request to the same digit right behind takes the pending entry.
   logic        cw_ff;
   logic [1:0]  ccmd_ff;
   logic [AW-1:0] cdig_ff;
   logic [15:0] cval_ff;
   entry_type   cmod;
   always_comb begin
      cmod = rd_ff;
      unique case (ccmd_ff)
         CMD_PAT:   cmod.nx = cval_ff;
         CMD_DUTY:  cmod.duty = cval_ff;
         CMD_START: cmod.chg = 1'b1;
         default:   cmod = rd_ff;
      endcase
   end

   logic req_store;
   assign req_store = req_tvalid && req_tready && cmd != CMD_TICK
                      && (32'(dig) < DIGITS);

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) rd_ff <= mem[ptr_ff];
      else if (req_store) begin
         if (cw_ff && cdig_ff == AW'(dig)) rd_ff <= cmod;
         else rd_ff <= mem[AW'(dig)];
      end
      if (we) mem[waddr] <= wdata;
      else if (cw_ff) mem[cdig_ff] <= cmod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff <= '0;
         mode_ff <= EFF_NONE;
         ovalid_ff <= 1'b0;
         cw_ff <= 1'b0;
         mul_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         if (csr_valid) mode_ff <= csr_data;
         cw_ff <= req_store;
         if (state_ff == ST_CALC) mul_ff <= mul_in;
         if (state_ff == ST_OUT && out_free) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
      end
   end

   // The fade product is formed from the operands registered in CALC.
   assign prod = mdu_ff * {1'b0, mfac_ff};

   always_comb begin
      out_in = pend_ff;
      if (mul_ff) out_in.du = prod[22:7];
   end

   always_ff @(posedge clock) begin
      ccmd_ff <= cmd;
      cdig_ff <= AW'(dig);
      cval_ff <= val;
      if (state_ff == ST_CALC) begin
         pend_ff <= pend_in;
         mdu_ff <= mdu_in;
         mfac_ff <= mfac_in;
      end
      if (state_ff == ST_OUT && out_free) out_ff <= out_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast = out_ff.last;
   assign rsp_tuser = {out_ff.bv, out_ff.dv, out_ff.sv};
   assign rsp_tdata = {6'd0, out_ff.br, out_ff.ss, out_ff.du, out_ff.sp, out_ff.idx};

endmodule
